>>> rtl/gray_code_phase_unwrap_macros.svh
// assertion macros shared by the rtl
// all of them sample on clk and are held off while rst is high
`ifndef GRAY_CODE_PHASE_UNWRAP_MACROS_SVH
`define GRAY_CODE_PHASE_UNWRAP_MACROS_SVH

// same-cycle implication
`define GCPU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcpu same-cycle check failed");

// next-cycle implication
`define GCPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcpu next-cycle check failed");

`endif

>>> rtl/gcpu_pkg.sv
`default_nettype none

package gcpu_pkg;

  localparam int GRAY_BITS       = 8;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int SAMPLE_BITS     = 8;
  localparam int THRESH_BITS     = 8;
  localparam int NUM_SAMPLES     = GRAY_BITS + 3;
  localparam int CODE2_BITS      = GRAY_BITS + 1;
  localparam int ORDER_BITS      = GRAY_BITS + 2;
  localparam int ABS_BITS        = ORDER_BITS + PHASE_FRAC_BITS;
  localparam int SPAN_BITS       = SAMPLE_BITS + THRESH_BITS;

  // sample slots inside one pixel
  localparam int COMP_IDX  = GRAY_BITS;
  localparam int BLACK_IDX = GRAY_BITS + 1;
  localparam int WHITE_IDX = GRAY_BITS + 2;

  localparam int IN_BITS  = NUM_SAMPLES * SAMPLE_BITS + PHASE_FRAC_BITS;
  localparam int IN_BYTES_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ABS_BITS + ORDER_BITS;
  localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(128);

  typedef logic [SAMPLE_BITS-1:0]        sample_t;
  typedef sample_t [NUM_SAMPLES-1:0]     sample_arr_t;
  typedef logic [PHASE_FRAC_BITS-1:0]    phase_t;
  typedef logic [THRESH_BITS-1:0]        thresh_t;
  typedef logic signed [ORDER_BITS-1:0]  order_t;
  typedef logic signed [ABS_BITS-1:0]    abs_t;

  typedef struct packed {
    sample_t mn;
    sample_t mx;
  } range_t;

  typedef struct packed {
    logic [GRAY_BITS-1:0]  k1;
    logic [CODE2_BITS-1:0] k2;
  } orders_t;

  function automatic sample_t min2(input sample_t a, input sample_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sample_t max2(input sample_t a, input sample_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gray_code_phase_unwrap.sv
`default_nettype none

// channel  | dir | payload                                        | handshake
// ---------+-----+------------------------------------------------+--------------------
// s_axis   | in  | tdata[103:0]: 11 samples, wrapped phase        | tvalid / tready
// m_axis   | out | tdata[39:0]: absolute phase, fringe order      | tvalid / tready
// cfg      | in  | cfg_wdata[7:0]: binarize threshold             | cfg_we, no wait
//
// one pixel per cycle sustained while m_axis is not stalled; two register
// stages: the input register, then the result register once that stage moves
// rst is synchronous, active high: clears both valid flags, threshold to 128
// the input register doubles as a skid stage, so a pixel is still taken while a
// finished result waits on m_axis_tready; s_axis_tready drops only when both
// stages are full and the result is stalled
module gray_code_phase_unwrap (
  input  wire                                     clk,
  input  wire                                     rst,
  // cfg
  input  wire                                     cfg_we,
  input  wire  [gcpu_pkg::THRESH_BITS-1:0]        cfg_wdata,
  // pixel in
  input  wire                                     s_axis_tvalid,
  output logic                                    s_axis_tready,
  // gray_sample_0..7, complement_sample, black_sample, white_sample (8b each),
  // wrapped_phase (16b) from bit 88
  input  wire  [gcpu_pkg::IN_BYTES_BITS-1:0]      s_axis_tdata,
  // result out
  output logic                                    m_axis_tvalid,
  input  wire                                     m_axis_tready,
  // absolute_phase [25:0], fringe_order [35:26], zero fill [39:36]
  output logic [gcpu_pkg::OUT_BYTES_BITS-1:0]     m_axis_tdata
);

  localparam int SB = gcpu_pkg::SAMPLE_BITS;
  localparam int NS = gcpu_pkg::NUM_SAMPLES;
  localparam int PF = gcpu_pkg::PHASE_FRAC_BITS;
  localparam int AB = gcpu_pkg::ABS_BITS;
  localparam int OB = gcpu_pkg::ORDER_BITS;

  // threshold register
  gcpu_pkg::thresh_t threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gcpu_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // input register
  logic                  in_valid;
  gcpu_pkg::sample_arr_t in_samples;
  gcpu_pkg::phase_t      in_phase;
  logic                  advance;
  logic                  in_xfer;

  // result stage moves when empty or being drained
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < NS; i++) begin
        in_samples[i] <= s_axis_tdata[i*SB +: SB];
      end
      in_phase <= s_axis_tdata[NS*SB +: PF];
    end
  end

  // single-pass datapath
  gcpu_pkg::range_t  range;
  gcpu_pkg::orders_t orders;
  gcpu_pkg::abs_t    abs_next;
  gcpu_pkg::order_t  order_next;

  gcpu_minmax u_minmax (
    .samples (in_samples),
    .range   (range)
  );

  gcpu_decode u_decode (
    .samples   (in_samples),
    .range     (range),
    .threshold (threshold),
    .orders    (orders)
  );

  gcpu_unwrap u_unwrap (
    .orders         (orders),
    .phase          (in_phase),
    .absolute_phase (abs_next),
    .fringe_order   (order_next)
  );

  // result register
  gcpu_pkg::abs_t   out_abs;
  gcpu_pkg::order_t out_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_abs   <= abs_next;
      out_order <= order_next;
    end
  end

  assign m_axis_tdata = gcpu_pkg::OUT_BYTES_BITS'({out_order, out_abs});

  // checks
  `include "gray_code_phase_unwrap_macros.svh"

  // whole turns only come from an invalid pixel, which carries order zero
  `GCPU_ASSERT_NOW(a_zero_phase_zero_order, m_axis_tvalid && (m_axis_tdata[PF-1:0] == '0), m_axis_tdata[AB +: OB] == '0)
  // the only negative order is minus one
  `GCPU_ASSERT_NOW(a_neg_order_is_minus_one, m_axis_tvalid && m_axis_tdata[AB+OB-1], m_axis_tdata[AB +: OB] == '1)
  // both stages full and stalled must push back on the input
  `GCPU_ASSERT_NOW(a_full_backpressure, in_valid && m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // a held pixel that moves forward shows up as a result
  `GCPU_ASSERT_NEXT(a_pixel_reaches_output, in_valid && advance, m_axis_tvalid)

endmodule

`default_nettype wire

>>> rtl/gcpu_minmax.sv
`default_nettype none

// min and max over all samples of a pixel, balanced compare tree
module gcpu_minmax (
  input  wire gcpu_pkg::sample_arr_t samples,
  output gcpu_pkg::range_t           range
);

  localparam int N = gcpu_pkg::NUM_SAMPLES;

  gcpu_pkg::sample_t mn_node [2*N-1];
  gcpu_pkg::sample_t mx_node [2*N-1];

  // heap layout: leaves at N-1 .. 2N-2, root at 0
  always_comb begin
    for (int i = 0; i < N; i++) begin
      mn_node[N-1+i] = samples[i];
      mx_node[N-1+i] = samples[i];
    end
    for (int i = N - 2; i >= 0; i--) begin
      mn_node[i] = gcpu_pkg::min2(mn_node[2*i+1], mn_node[2*i+2]);
      mx_node[i] = gcpu_pkg::max2(mx_node[2*i+1], mx_node[2*i+2]);
    end
    range.mn = mn_node[0];
    range.mx = mx_node[0];
  end

endmodule

`default_nettype wire

>>> rtl/gcpu_decode.sv
`default_nettype none

// binarize the code samples and turn both gray codes into fringe orders
module gcpu_decode (
  input  wire gcpu_pkg::sample_arr_t samples,
  input  wire gcpu_pkg::range_t      range,
  input  wire gcpu_pkg::thresh_t     threshold,
  output gcpu_pkg::orders_t          orders
);

  localparam int GB = gcpu_pkg::GRAY_BITS;
  localparam int CB = gcpu_pkg::CODE2_BITS;
  localparam int TB = gcpu_pkg::THRESH_BITS;
  localparam int PB = gcpu_pkg::SPAN_BITS;

  logic [PB-1:0] span;
  logic [CB-1:0] bits;
  logic [GB-1:0] code1;
  logic [CB-1:0] code2;
  logic [GB-1:0] bin1;
  logic [CB-1:0] bin2;
  logic [CB:0]   bin2_inc;
  gcpu_pkg::sample_t diff;

  always_comb begin
    span = PB'(threshold) * PB'(range.mx - range.mn);
    // first sample is the msb of the code
    for (int k = 0; k < CB; k++) begin
      diff = samples[k] - range.mn;
      bits[CB-1-k] = ({diff, TB'(0)} > span);
    end
    code1 = bits[CB-1:1];
    code2 = bits;
    for (int i = 0; i < GB; i++) begin
      bin1[i] = ^(code1 >> i);
    end
    for (int i = 0; i < CB; i++) begin
      bin2[i] = ^(code2 >> i);
    end
    bin2_inc  = {1'b0, bin2} + (CB+1)'(1);
    orders.k1 = bin1;
    orders.k2 = bin2_inc[CB:1];
  end

endmodule

`default_nettype wire

>>> rtl/gcpu_unwrap.sv
`default_nettype none

// pick the order by phase quadrant and build the absolute phase
module gcpu_unwrap (
  input  wire gcpu_pkg::orders_t orders,
  input  wire gcpu_pkg::phase_t  phase,
  output gcpu_pkg::abs_t         absolute_phase,
  output gcpu_pkg::order_t       fringe_order
);

  localparam int PF = gcpu_pkg::PHASE_FRAC_BITS;
  localparam int OB = gcpu_pkg::ORDER_BITS;
  localparam gcpu_pkg::phase_t QUARTER       = gcpu_pkg::phase_t'(1) << (PF - 2);
  localparam gcpu_pkg::phase_t THREE_QUARTER = gcpu_pkg::phase_t'(3) << (PF - 2);

  gcpu_pkg::order_t order;

  always_comb begin
    priority if (phase == '0) begin
      order = '0;
    end else if (phase <= QUARTER) begin
      order = gcpu_pkg::order_t'(orders.k2);
    end else if (phase >= THREE_QUARTER) begin
      order = gcpu_pkg::order_t'(orders.k2) - OB'(1);
    end else begin
      order = gcpu_pkg::order_t'(orders.k1);
    end
    // phase is below one turn, so order * turn + phase is a plain concatenation
    fringe_order   = order;
    absolute_phase = {order, phase};
  end

endmodule

`default_nettype wire

>>> tb/tb_gray_code_phase_unwrap.sv
`default_nettype none

module tb_gray_code_phase_unwrap;
  import gcpu_pkg::*;

  // phase boundaries in 1/2^PHASE_FRAC_BITS turn
  localparam int QUARTER        = 1 << (PHASE_FRAC_BITS - 2);
  localparam int THREE_QUARTERS = 3 << (PHASE_FRAC_BITS - 2);
  localparam int FILL_BITS      = OUT_BYTES_BITS - OUT_BITS;
  localparam int NUM_PHASES     = 6;
  localparam int PIXELS_PER_PHASE = 217;
  localparam int CYCLE_LIMIT    = 200000;

  // result transfer as it sits on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [FILL_BITS-1:0] fill;
    order_t               order;
    abs_t                 abs_phase;
  } unwrap_t;

  // predicts the unwrapped phase of every accepted pixel and checks the
  // result stream against it in order
  class unwrap_scoreboard;
    thresh_t thr;
    unwrap_t expected_unwraps[$];
    int      errors;
    int      checked;

    function new();
      thr     = THRESH_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function unwrap_t unwrap_pixel(sample_arr_t s, phase_t p);
      sample_t               lo;
      sample_t               hi;
      logic [SPAN_BITS-1:0]  span;
      logic [CODE2_BITS-1:0] code;
      logic [CODE2_BITS-1:0] idx;
      logic [ORDER_BITS-1:0] k2;
      int                    ord;
      unwrap_t               r;
      lo = '1;
      hi = '0;
      for (int k = 0; k < NUM_SAMPLES; k++) begin
        if (s[k] < lo) lo = s[k];
        if (s[k] > hi) hi = s[k];
      end
      span = thr * (hi - lo);
      // gray bits msb first, complementary bit last
      code = '0;
      for (int k = 0; k < CODE2_BITS; k++)
        code = {code[CODE2_BITS-2:0], ({s[k] - lo, 8'h00} > span)};
      // gray to binary as a running xor from the top; the upper eight bits
      // of the index are the gray order decoded on its own
      idx[CODE2_BITS-1] = code[CODE2_BITS-1];
      for (int k = CODE2_BITS - 2; k >= 0; k--)
        idx[k] = idx[k+1] ^ code[k];
      k2 = (ORDER_BITS'(idx) + 1'b1) >> 1;
      r = '0;
      if (p != 0) begin
        if (p <= QUARTER)
          ord = k2;
        else if (p >= THREE_QUARTERS)
          ord = int'(k2) - 1;
        else
          ord = idx[CODE2_BITS-1:1];
        r.order     = order_t'(ord);
        r.abs_phase = abs_t'(ord * (1 << PHASE_FRAC_BITS) + int'(p));
      end
      return r;
    endfunction

    function void note_pixel(sample_arr_t s, phase_t p);
      expected_unwraps.push_back(unwrap_pixel(s, p));
    endfunction

    function void check_result(unwrap_t got);
      unwrap_t want;
      if (expected_unwraps.size() == 0) begin
        $display("%0t: result with no pixel pending: abs %0d order %0d",
                 $time, got.abs_phase, got.order);
        errors++;
        return;
      end
      want = expected_unwraps.pop_front();
      checked++;
      if (got.abs_phase !== want.abs_phase) begin
        $display("%0t: absolute_phase expected %0d actual %0d",
                 $time, want.abs_phase, got.abs_phase);
        errors++;
      end
      if (got.order !== want.order) begin
        $display("%0t: fringe_order expected %0d actual %0d",
                 $time, want.order, got.order);
        errors++;
      end
      if (got.fill !== want.fill) begin
        $display("%0t: zero fill expected %0h actual %0h",
                 $time, want.fill, got.fill);
        errors++;
      end
    endfunction

    function int pending();
      return expected_unwraps.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  thresh_t                   cfg_wdata = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_BYTES_BITS-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_BYTES_BITS-1:0] m_axis_tdata;

  unwrap_scoreboard sb = new();

  // idle rates in percent per cycle
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int pixels_sent = 0;
  int cycle_count = 0;

  gray_code_phase_unwrap dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
    $display("** gray_code_phase_unwrap: FAILED **");
    $finish;
  end

  // result side: check each transfer seen at the edge, then pick next tready
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_result(unwrap_t'(m_axis_tdata));
      m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one pixel transfer; valid stays high into the next pixel unless a gap is drawn
  task automatic send_pixel(sample_arr_t s, phase_t p);
    int gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
      gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BYTES_BITS'({p, s});
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(s, p);
    pixels_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // only called with the pipeline empty
  task automatic write_threshold(thresh_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.thr = v;
  endtask

  // code bits msb first pick dark or bright level; black and white frames
  // carry the two levels
  function automatic sample_arr_t coded_samples(sample_t lo, sample_t hi,
                                                logic [CODE2_BITS-1:0] code);
    sample_arr_t s;
    for (int k = 0; k < CODE2_BITS; k++)
      s[k] = code[CODE2_BITS-1-k] ? hi : lo;
    s[BLACK_IDX] = lo;
    s[WHITE_IDX] = hi;
    return s;
  endfunction

  // mostly uniform, with the order boundaries and invalid phase drawn often
  function automatic phase_t pick_phase();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    if (r < 22) begin
      case ($urandom_range(7))
        0:       return phase_t'(1);
        1:       return phase_t'(QUARTER - 1);
        2:       return phase_t'(QUARTER);
        3:       return phase_t'(QUARTER + 1);
        4:       return phase_t'(THREE_QUARTERS - 1);
        5:       return phase_t'(THREE_QUARTERS);
        6:       return phase_t'(THREE_QUARTERS + 1);
        default: return '1;
      endcase
    end
    return phase_t'($urandom);
  endfunction

  // most pixels look like a real capture: two levels plus noise; the rest
  // are raw noise
  task automatic random_pixel(output sample_arr_t s, output phase_t p);
    int                    lo;
    int                    hi;
    int                    spread;
    int                    v;
    logic [CODE2_BITS-1:0] code;
    if ($urandom_range(99) < 70) begin
      lo     = $urandom_range(0, 160);
      hi     = $urandom_range(lo, 255);
      spread = $urandom_range(0, 24);
      // lowest and highest order codes now and then
      case ($urandom_range(9))
        0:       code = '0;
        1:       code = CODE2_BITS'(1) << (CODE2_BITS - 1);
        default: code = CODE2_BITS'($urandom);
      endcase
      for (int k = 0; k < NUM_SAMPLES; k++) begin
        if (k < CODE2_BITS)
          v = code[CODE2_BITS-1-k] ? hi : lo;
        else if (k == BLACK_IDX)
          v = lo;
        else
          v = hi;
        v = v + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        s[k] = sample_t'(v);
      end
    end else begin
      for (int k = 0; k < NUM_SAMPLES; k++)
        s[k] = sample_t'($urandom);
    end
    p = pick_phase();
  endtask

  initial begin
    sample_arr_t s;
    phase_t      p;
    thresh_t     thr_plan [NUM_PHASES];
    int          n_directed;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed pixels at the reset threshold; sender idles lightly, receiver heavily
    tx_idle_pct = 11;
    rx_idle_pct = 64;
    // invalid phase on a flat dark pixel
    send_pixel(coded_samples(8'd0, 8'd0, '0), '0);
    // flat bright pixel at the top phase gives order -1
    send_pixel(coded_samples(8'd255, 8'd255, '1), '1);
    send_pixel(coded_samples(8'd77, 8'd77, '0), phase_t'(THREE_QUARTERS));
    send_pixel(coded_samples(8'd77, 8'd77, '0), phase_t'(THREE_QUARTERS - 1));
    send_pixel(coded_samples(8'd0, 8'd255, '0), phase_t'(1));
    // lowest order from a real code at high phase, negative result
    send_pixel(coded_samples(8'd10, 8'd240, '0), phase_t'(THREE_QUARTERS));
    // highest order: complementary index 256 at the quarter boundary
    send_pixel(coded_samples(8'd0, 8'd255, 9'h100), phase_t'(QUARTER));
    send_pixel(coded_samples(8'd0, 8'd255, 9'h100), phase_t'(QUARTER + 1));
    send_pixel(coded_samples(8'd0, 8'd255, 9'h100), '1);
    send_pixel(coded_samples(8'd0, 8'd255, '1), phase_t'(THREE_QUARTERS - 1));
    send_pixel(coded_samples(8'd0, 8'd255, '1), phase_t'(THREE_QUARTERS));
    send_pixel(coded_samples(8'd0, 8'd255, 9'h0ff), phase_t'(QUARTER - 1));
    // invalid phase with a nonzero code
    send_pixel(coded_samples(8'd0, 8'd255, 9'h155), '0);
    // exact threshold tie: 256*127 equals 128*254, so 127 reads as dark
    s = coded_samples(8'd127, 8'd128, 9'h0aa);
    s[BLACK_IDX] = 8'd0;
    s[WHITE_IDX] = 8'd254;
    send_pixel(s, phase_t'(16'h8000));
    // black frame brighter than white frame
    s = coded_samples(8'd30, 8'd200, 9'h1ab);
    s[BLACK_IDX] = 8'd220;
    s[WHITE_IDX] = 8'd5;
    send_pixel(s, phase_t'(16'h4321));
    n_directed = pixels_sent;

    // threshold per random phase, extremes first
    thr_plan[0] = 8'd0;
    thr_plan[1] = 8'd255;
    thr_plan[2] = 8'd1;
    thr_plan[3] = thresh_t'($urandom_range(2, 254));
    thr_plan[4] = 8'd128;
    thr_plan[5] = thresh_t'($urandom_range(2, 254));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_threshold(thr_plan[ph]);
      // light sender and heavy receiver idling, then swapped, then none
      case (ph / 2)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 64;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        random_pixel(s, p);
        send_pixel(s, p);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("run covered %0d pixels (%0d directed), %0d results checked, %0d mismatches",
             pixels_sent, n_directed, sb.checked, sb.errors);
    $display("thresholds 128, 0, 255, 1, 128 and two random; three idle patterns; %0d cycles",
             cycle_count);
    if (sb.errors == 0)
      $display("** gray_code_phase_unwrap: PASSED **");
    else
      $display("** gray_code_phase_unwrap: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
